// ===== design/deq_pkg.sv =====
package deq_pkg;

    // Ring size and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;

    // Fixed field widths of the channels.
    localparam int CMD_W  = 3;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Operation codes carried by each request beat.
    typedef enum logic [CMD_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_READ_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_BACK  = 3'd4,
        OP_POP_BACK   = 3'd5
    } t_op;

    // Status codes returned with each response beat.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== design/deq_if.sv =====
// Request channel: one operation per beat.
interface deq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [deq_pkg::CMD_W-1:0]            cmd;
    logic signed [deq_pkg::WORD_W-1:0]    push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

// Response channel: one result per beat.
interface deq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [deq_pkg::WORD_W-1:0]    read_value;
    logic [deq_pkg::STAT_W-1:0]           status;
    logic [deq_pkg::OCC_W-1:0]            occupancy;

    modport source (output valid, output read_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input read_value, input status, input occupancy,
                    output ready);
endinterface

// ===== design/deq_ctrl.sv =====
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output deq_pkg::t_dp_cmd  o_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: take a beat, run it in the execute state, then hold the result.
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = deq_pkg::S_EXEC;
                end
            end
            deq_pkg::S_EXEC: begin
                n_state = deq_pkg::S_RESP;
            end
            deq_pkg::S_RESP: begin
                if (i_out_ready) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            deq_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            deq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            deq_pkg::S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/deq_dp.sv =====
module deq_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  deq_pkg::t_dp_cmd                   i_cmd,
    input  logic [deq_pkg::CMD_W-1:0]          i_op,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_word,
    output logic signed [deq_pkg::WORD_W-1:0]  o_read_value,
    output logic [deq_pkg::STAT_W-1:0]         o_status,
    output logic [deq_pkg::OCC_W-1:0]          o_occupancy
);

    localparam int IDX_W = deq_pkg::IDX_W;
    localparam int CNT_W = deq_pkg::CNT_W;
    localparam int SUM_W = deq_pkg::SUM_W;

    // Latched request.
    deq_pkg::t_op                 r_op;
    logic [deq_pkg::WORD_W-1:0]   r_word;

    // Ring pointers.
    logic [IDX_W-1:0]             r_head;
    logic [IDX_W-1:0]             n_head;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;

    // Result registers.
    logic [deq_pkg::WORD_W-1:0]   r_rd;
    deq_pkg::t_status             r_status;
    deq_pkg::t_status             n_status;
    logic [deq_pkg::OCC_W-1:0]    r_occ;

    // Slot storage.
    logic [deq_pkg::WORD_W-1:0]   mem [deq_pkg::DEPTH];

    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;

    logic                         full;
    logic                         empty;
    logic [SUM_W-1:0]             tail_sum;
    logic [SUM_W-1:0]             back_sum;
    logic [IDX_W-1:0]             tail_pos;
    logic [IDX_W-1:0]             back_pos;
    logic [IDX_W-1:0]             head_inc;
    logic [IDX_W-1:0]             head_dec;

    // Capture the request beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= deq_pkg::t_op'(i_op);
            r_word <= i_word;
        end
    end

    // Ring arithmetic, each wrap a single compare against the ring bounds.
    always_comb begin
        full     = (r_count == CNT_W'(deq_pkg::DEPTH));
        empty    = (r_count == '0);
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        back_sum = tail_sum - SUM_W'(1);
        tail_pos = (tail_sum >= SUM_W'(deq_pkg::DEPTH))
                 ? IDX_W'(tail_sum - SUM_W'(deq_pkg::DEPTH)) : IDX_W'(tail_sum);
        back_pos = (back_sum >= SUM_W'(deq_pkg::DEPTH))
                 ? IDX_W'(back_sum - SUM_W'(deq_pkg::DEPTH)) : IDX_W'(back_sum);
        head_inc = (r_head == IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
        head_dec = (r_head == '0) ? IDX_W'(deq_pkg::DEPTH - 1) : r_head - IDX_W'(1);
    end

    // Decode the operation into pointer updates and slot accesses.
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        wr_en    = 1'b0;
        wr_addr  = tail_pos;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        case (r_op)
            deq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            deq_pkg::OP_READ_FRONT: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    rd_en = 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - CNT_W'(1);
                end
            end
            deq_pkg::OP_READ_BACK: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = back_pos;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = deq_pkg::ST_OK;
            end
        endcase
    end

    // Pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Slot memory with a registered read port; a non-read returns zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_word;
        end
        if (i_cmd.exec) begin
            r_rd <= rd_en ? mem[rd_addr] : '0;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_occ    <= deq_pkg::OCC_W'(n_count);
        end
    end

    assign o_read_value = r_rd;
    assign o_status     = r_status;
    assign o_occupancy  = r_occ;

endmodule

// ===== design/double_ended_queue_engine.sv =====
// Double-ended queue of signed 32-bit words in a ring of deq_pkg::DEPTH slots. Each request
// beat carries one operation (push back, push front, read front, pop front, read back, pop
// back) and yields exactly one response beat with the word read (zero unless a read
// succeeds), a status (ok, empty, full) and the occupancy after the operation. A push into
// a full ring is dropped and reports full; a read or pop on an empty ring reports empty and
// changes nothing; unused codes are no-ops. The block handles one operation at a time: a
// beat is taken in the idle state, the ring is updated and the slot memory is read in the
// execute state, and the result beat is offered in the response state until it is taken;
// no new beat is taken before then. The request register and the registered read port of
// the slot memory set these steps. Slots need no clearing after reset; only occupied slots
// are ever read.
module double_ended_queue_engine (
    input  logic   i_clk,
    input  logic   i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);

    deq_pkg::t_dp_cmd dp_cmd;

    // Sequencing of request, execution and response.
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (dp_cmd)
    );

    // Ring pointers, slot memory and result registers.
    deq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_op         (i_req.cmd),
        .i_word       (i_req.push_value),
        .o_read_value (o_rsp.read_value),
        .o_status     (o_rsp.status),
        .o_occupancy  (o_rsp.occupancy)
    );

endmodule

// ===== design/deq_checker.sv =====
module deq_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_read_value,
    input  logic [deq_pkg::STAT_W-1:0]         i_status,
    input  logic [deq_pkg::OCC_W-1:0]          i_occupancy
);

    // A stalled response beat holds its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_value)
            && $stable(i_status) && $stable(i_occupancy))
        else $error("response beat changed while stalled");

    // No new request is taken while a result waits.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_in_valid && i_in_ready))
        else $error("request accepted while a response is pending");

    // A failed operation never returns a word.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != deq_pkg::ST_OK) |-> i_read_value == '0)
        else $error("nonzero word on a failed operation");

    // A dropped push only happens with every slot in use.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == deq_pkg::ST_FULL)
            |-> i_occupancy == deq_pkg::OCC_W'(deq_pkg::DEPTH))
        else $error("full status with free slots");

endmodule

bind double_ended_queue_engine deq_checker u_deq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_read_value (o_rsp.read_value),
    .i_status     (o_rsp.status),
    .i_occupancy  (o_rsp.occupancy)
);
